/* sv/grid_word_search_counter_macros.svh */
// Assertion macros shared by the grid word search counter RTL.
`ifndef GRID_WORD_SEARCH_COUNTER_MACROS_SVH
`define GRID_WORD_SEARCH_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define GWSC_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define GWSC_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/gwsc_pkg.sv */
// Types, constants and helper functions for the grid word search counter.
`default_nettype none

package gwsc_pkg;

	localparam int unsigned GWSC_MAX_WIDTH   = 256;
	localparam int unsigned GWSC_COUNT_BITS  = 18;
	localparam int unsigned GWSC_CFG_W       = 9;
	localparam int unsigned GWSC_SYM_W       = 8;
	localparam int unsigned GWSC_NM_W        = 3;
	localparam int unsigned GWSC_HEAD_N      = 4;
	localparam int unsigned GWSC_WIN_N       = 7;
	localparam int unsigned GWSC_PEND_N      = 3;
	localparam logic [GWSC_CFG_W-1:0] GWSC_WIDTH_RESET = 9'd140;
	localparam logic [GWSC_CFG_W-1:0] GWSC_WIDTH_MIN   = 9'd4;

	localparam logic [GWSC_SYM_W-1:0] CHAR_X = 8'h58;
	localparam logic [GWSC_SYM_W-1:0] CHAR_M = 8'h4D;
	localparam logic [GWSC_SYM_W-1:0] CHAR_A = 8'h41;
	localparam logic [GWSC_SYM_W-1:0] CHAR_S = 8'h53;

	typedef enum logic [2:0] {
		CODE_OTHER = 3'd0,
		CODE_X     = 3'd1,
		CODE_M     = 3'd2,
		CODE_A     = 3'd3,
		CODE_S     = 3'd4
	} code_t;

	// Codes of one column: r1 is the row just above, r3 three rows up.
	typedef struct packed {
		code_t r3;
		code_t r2;
		code_t r1;
	} hist_t;

	function automatic code_t sym_code(input logic [GWSC_SYM_W-1:0] b);
		code_t c;
		case (b)
			CHAR_X:  c = CODE_X;
			CHAR_M:  c = CODE_M;
			CHAR_A:  c = CODE_A;
			CHAR_S:  c = CODE_S;
			default: c = CODE_OTHER;
		endcase
		return c;
	endfunction

	// XMAS read forward or backward, oldest cell first.
	function automatic logic is_word(input code_t a, input code_t b, input code_t c,
			input code_t d);
		return (a == CODE_X && b == CODE_M && c == CODE_A && d == CODE_S) ||
			(a == CODE_S && b == CODE_A && c == CODE_M && d == CODE_X);
	endfunction

endpackage

`default_nettype wire

/* sv/grid_word_search_counter.sv */
// Top level of the grid word search counter: XMAS counting over a streamed grid.
//
// Usage: grid characters enter on the s_axis channel in row-major order, one
// byte per word, with s_axis_tuser high on the first character of a grid (it
// clears column, row count, row tail and the running total). cfg_data sets the
// row width (clamped to 4..MAX_WIDTH); write it only while the block is idle.
// Each character yields one word on m_axis: the matches that end at this cell
// (row, column, both diagonals, 0..4) and the saturating running total.
// An accepted character waits in the input register and, when it moves on, its
// result word is registered in the result register. Throughput: one character
// per cycle while m_axis_tready stays high; every cell is a fixed set of window
// compares plus one line-store read issued four columns ahead.
// Three earlier rows live in a line store with one read and one write per cycle
// and per-entry valid bits; the end-of-row updates are queued and written one
// at a time when no direct write is due, with bypass on the prefetch read.
// Reset: all control state clears at once, the line store reads as empty,
// the width returns to 140. No clearing pass is needed.
// Stall: while m_axis_tready is low the result word holds and, if the input
// register is empty, one more character is taken into it; then s_axis_tready drops.
`default_nettype none
`include "grid_word_search_counter_macros.svh"

module grid_word_search_counter
	import gwsc_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = GWSC_MAX_WIDTH,
	parameter int unsigned COUNT_BITS = GWSC_COUNT_BITS,
	localparam int unsigned ODATA_W   = ((COUNT_BITS + GWSC_NM_W + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [GWSC_SYM_W-1:0] s_axis_tdata,  // [7:0] symbol
	input  wire logic                  s_axis_tuser,  // [0] grid_start
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [ODATA_W-1:0]         m_axis_tdata,  // [2:0] new_matches, then match_total
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [GWSC_CFG_W-1:0] cfg_data
);

	localparam int unsigned AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned DEPTH = 1 << AW;
	localparam int unsigned WB    = ((AW + 2) > (GWSC_CFG_W + 1)) ? (AW + 2) : (GWSC_CFG_W + 1);
	localparam logic [1:0]  ROWS_FULL = 2'd3;

	// configuration
	logic [GWSC_CFG_W-1:0] grid_width_q;

	// input and result registers
	logic                  v_s1;
	logic [GWSC_SYM_W-1:0] sym_s1;
	logic                  start_s1;
	logic                  v_s2;
	logic [GWSC_NM_W-1:0]  nm_s2;
	logic [COUNT_BITS-1:0] tot_s2;

	// grid state
	logic [AW-1:0]         col_q;
	logic [1:0]            rows_q;
	hist_t                 rw_q;
	logic [COUNT_BITS-1:0] tot_q;
	hist_t                 head_q [GWSC_HEAD_N];
	hist_t                 win_q [GWSC_WIN_N-1];

	// line store, prefetch and queued end-of-row writes
	hist_t                 mem [DEPTH];
	logic [DEPTH-1:0]      hv_q;
	hist_t                 mem_rd_q;
	logic                  rd_hv_q;
	logic                  fwd_hit_q;
	hist_t                 fwd_d_q;
	logic [GWSC_PEND_N-1:0] pend_v_q;
	logic [AW-1:0]         pend_a_q [GWSC_PEND_N];
	hist_t                 pend_d_q [GWSC_PEND_N];

	// combinational
	logic                  fire;
	logic [WB-1:0]         w_ext;
	logic [WB-1:0]         max_ext;
	logic [WB-1:0]         w_eff;
	logic [AW-1:0]         c;
	logic [WB-1:0]         c_ext;
	logic                  last;
	logic                  c_ge3;
	logic [1:0]            rows;
	hist_t                 rw;
	logic [COUNT_BITS-1:0] tot;
	code_t                 code;
	hist_t                 rd;
	hist_t                 win [GWSC_WIN_N];
	logic                  hz, vt, ul, ur;
	logic [GWSC_NM_W-1:0]  nm;
	logic [COUNT_BITS:0]   sum;
	logic [COUNT_BITS-1:0] tot_next;
	logic [AW-1:0]         ca [GWSC_HEAD_N];
	hist_t                 cm [GWSC_HEAD_N];
	code_t                 ck [GWSC_HEAD_N];
	logic                  dir_we;
	logic                  mem_we;
	logic [AW-1:0]         mem_wa;
	hist_t                 mem_wd;
	logic [AW-1:0]         ra;
	logic                  fwd_hit;
	hist_t                 fwd_d;

	assign cfg_ready     = 1'b1;
	assign fire          = v_s1 && (!v_s2 || m_axis_tready);
	assign s_axis_tready = !v_s1 || fire;
	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = ODATA_W'({tot_s2, nm_s2});

	always_comb begin
		w_ext   = WB'(grid_width_q);
		max_ext = WB'(MAX_WIDTH);
		if (w_ext < WB'(GWSC_WIDTH_MIN)) begin
			w_eff = WB'(GWSC_WIDTH_MIN);
		end else if (w_ext > max_ext) begin
			w_eff = max_ext;
		end else begin
			w_eff = w_ext;
		end

		c     = start_s1 ? '0 : col_q;
		rows  = start_s1 ? '0 : rows_q;
		rw    = start_s1 ? '0 : rw_q;
		tot   = start_s1 ? '0 : tot_q;
		c_ext = WB'(c);
		last  = (c_ext + WB'(1)) >= w_eff;
		c_ge3 = c_ext >= WB'(3);
		code  = sym_code(sym_s1);

		// history of columns c-3 .. c+3; a row starts from the head copies
		rd = fwd_hit_q ? fwd_d_q : (rd_hv_q ? mem_rd_q : '0);
		if (c == '0) begin
			for (int k = 0; k < 3; k++) begin
				win[k] = '0;
			end
			for (int k = 0; k < GWSC_HEAD_N; k++) begin
				win[k+3] = head_q[k];
			end
		end else begin
			for (int k = 0; k < GWSC_WIN_N - 1; k++) begin
				win[k] = win_q[k];
			end
			win[GWSC_WIN_N-1] = rd;
		end

		hz = c_ge3 && is_word(rw.r3, rw.r2, rw.r1, code);
		vt = (rows == ROWS_FULL) && is_word(win[3].r3, win[3].r2, win[3].r1, code);
		ul = (rows == ROWS_FULL) && c_ge3 && is_word(win[0].r3, win[1].r2, win[2].r1, code);
		ur = (rows == ROWS_FULL) && ((c_ext + WB'(3)) < w_eff) &&
			is_word(win[6].r3, win[5].r2, win[4].r1, code);
		nm = GWSC_NM_W'(hz) + GWSC_NM_W'(vt) + GWSC_NM_W'(ul) + GWSC_NM_W'(ur);

		sum      = {1'b0, tot} + (COUNT_BITS+1)'(nm);
		tot_next = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];

		// pushes into columns c-3 .. c
		ck[0] = rw.r3;
		ck[1] = rw.r2;
		ck[2] = rw.r1;
		ck[3] = code;
		ca[0] = c - AW'(3);
		ca[1] = c - AW'(2);
		ca[2] = c - AW'(1);
		ca[3] = c;
		for (int k = 0; k < GWSC_HEAD_N; k++) begin
			cm[k] = '{r3: win[k].r2, r2: win[k].r1, r1: ck[k]};
		end

		dir_we = fire && c_ge3;
		mem_we = dir_we || pend_v_q[0];
		mem_wa = dir_we ? ca[0] : pend_a_q[0];
		mem_wd = dir_we ? cm[0] : pend_d_q[0];

		ra      = c + AW'(4);
		fwd_hit = 1'b0;
		fwd_d   = '0;
		for (int p = 0; p < GWSC_PEND_N; p++) begin
			if (pend_v_q[p] && pend_a_q[p] == ra) begin
				fwd_hit = 1'b1;
				fwd_d   = pend_d_q[p];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= GWSC_WIDTH_RESET;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			col_q        <= '0;
			rows_q       <= '0;
			rw_q         <= '0;
			tot_q        <= '0;
			hv_q         <= '0;
			rd_hv_q      <= 1'b0;
			fwd_hit_q    <= 1'b0;
			pend_v_q     <= '0;
			for (int i = 0; i < GWSC_HEAD_N; i++) begin
				head_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				grid_width_q <= cfg_data;
			end
			if (s_axis_tready) begin
				v_s1 <= s_axis_tvalid;
			end
			if (!v_s2 || m_axis_tready) begin
				v_s2 <= v_s1;
			end
			if (mem_we) begin
				hv_q[mem_wa] <= 1'b1;
			end
			if (fire) begin
				col_q     <= last ? '0 : c + AW'(1);
				rows_q    <= (last && rows != ROWS_FULL) ? rows + 2'd1 : rows;
				rw_q      <= last ? '0 : hist_t'{r3: rw.r2, r2: rw.r1, r1: code};
				tot_q     <= tot_next;
				rd_hv_q   <= hv_q[ra];
				fwd_hit_q <= fwd_hit;
				for (int i = 0; i < GWSC_HEAD_N; i++) begin
					if (dir_we && ca[0] == AW'(i)) begin
						head_q[i] <= cm[0];
					end
					if (last) begin
						for (int k = 1; k < GWSC_HEAD_N; k++) begin
							if (ca[k] == AW'(i)) begin
								head_q[i] <= cm[k];
							end
						end
					end
				end
			end
			// end-of-row pushes drain one a cycle, behind the direct push
			if (fire && last) begin
				pend_v_q <= '1;
			end else if (!dir_we && pend_v_q[0]) begin
				pend_v_q <= {1'b0, pend_v_q[GWSC_PEND_N-1:1]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sym_s1   <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
		if (fire) begin
			nm_s2    <= nm;
			tot_s2   <= tot_next;
			mem_rd_q <= mem[ra];
			fwd_d_q  <= fwd_d;
			for (int k = 0; k < GWSC_WIN_N - 1; k++) begin
				win_q[k] <= win[k+1];
			end
		end
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (fire && last) begin
			for (int p = 0; p < GWSC_PEND_N; p++) begin
				pend_a_q[p] <= ca[p+1];
				pend_d_q[p] <= cm[p+1];
			end
		end else if (!dir_we && pend_v_q[0]) begin
			for (int p = 0; p < GWSC_PEND_N - 1; p++) begin
				pend_a_q[p] <= pend_a_q[p+1];
				pend_d_q[p] <= pend_d_q[p+1];
			end
		end
	end

	`GWSC_ASSERT_IMP(a_no_push_over_queue, dir_we, pend_v_q == '0, "push while queue busy")
	`GWSC_ASSERT_NXT(a_queue_load, fire && last, pend_v_q == '1, "row-end queue not loaded")
	`GWSC_ASSERT_IMP(a_hold_when_full, v_s1 && v_s2 && !m_axis_tready, !s_axis_tready, "taken when full")

endmodule

`default_nettype wire
